/* rtl/shr_pkg.sv */
package shr_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int FRAME_BITS_DEF = 48;
    localparam int SIZE_BITS      = 25;
    localparam int LIMIT_BITS     = 31;
    localparam int INTV_BITS      = 16;
    localparam int DISC_BITS      = 32;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 31;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 31'd1073741824;
    localparam logic [INTV_BITS-1:0]  INTV_RESET  = 16'd1;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_TAKE    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_NEWEST,
        ST_DECIDE,
        ST_DROP_READ,
        ST_DROP,
        ST_MOD,
        ST_TAKE_READ,
        ST_TAKE_CHECK,
        ST_TRIM_READ,
        ST_TRIM,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // latch input item
        logic rd_newest;   // read slot of newest entry
        logic rd_oldest;   // read slot of oldest entry
        logic drop_oldest; // evict oldest (uses read data)
        logic drop_newest; // discard newest (uses read data)
        logic pop_newest;  // pop newest as result
        logic write_new;   // append captured entry
        logic clear;       // empty ring
        logic mod_start;
        logic mod_step;
        logic set_rewind;
        logic set_due;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic cap_ok;      // capture passes basic checks
        logic newer;       // input frame newer than read entry
        logic over_limit;  // byte total above limit
        logic rewind_ok;
        logic mod_done;
        logic mod_zero;
    } status_t;

endpackage

/* rtl/shr_ram.sv */
module shr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/shr_ctrl.sv */
module shr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  shr_pkg::status_t  status,
    output shr_pkg::cmd_t     cmd
);

    shr_pkg::state_t state_reg, state_next;
    logic            ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= shr_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign in_ready  = (state_reg == shr_pkg::ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            shr_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = shr_pkg::ST_READ_NEWEST;
                end
            end
            shr_pkg::ST_READ_NEWEST: begin
                unique case (status.op)
                    shr_pkg::OP_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = shr_pkg::ST_OUT;
                    end
                    shr_pkg::OP_TAKE: begin
                        cmd.rd_newest = 1'b1;
                        state_next    = shr_pkg::ST_TAKE_READ;
                    end
                    default: begin
                        cmd.rd_newest = 1'b1;
                        cmd.mod_start = 1'b1;
                        state_next    = shr_pkg::ST_DECIDE;
                    end
                endcase
            end
            shr_pkg::ST_DECIDE: begin
                // newest entry's frame is on the read port now
                if (status.op == shr_pkg::OP_CAPTURE) begin
                    if (status.cap_ok && (status.empty || status.newer)) begin
                        if (status.full) begin
                            cmd.rd_oldest = 1'b1;
                            state_next    = shr_pkg::ST_DROP_READ;
                        end else begin
                            cmd.write_new = 1'b1;
                            state_next    = shr_pkg::ST_TRIM_READ;
                        end
                    end else begin
                        state_next = shr_pkg::ST_OUT;
                    end
                end else begin
                    if (status.empty || status.newer) begin
                        cmd.set_due = 1'b1;
                    end
                    cmd.rd_oldest = 1'b1;
                    state_next    = shr_pkg::ST_MOD;
                end
            end
            shr_pkg::ST_DROP_READ: begin
                // keep the oldest slot on the read port for the drop
                cmd.rd_oldest = 1'b1;
                state_next    = shr_pkg::ST_DROP;
            end
            shr_pkg::ST_DROP: begin
                cmd.drop_oldest = 1'b1;
                cmd.write_new   = 1'b1;
                state_next      = shr_pkg::ST_TRIM_READ;
            end
            shr_pkg::ST_MOD: begin
                // oldest frame stays on the read port for the rewind test
                cmd.rd_oldest = 1'b1;
                if (status.mod_done) begin
                    cmd.set_rewind = 1'b1;
                    state_next     = shr_pkg::ST_OUT;
                end else begin
                    cmd.mod_step = 1'b1;
                end
            end
            shr_pkg::ST_TAKE_READ: begin
                state_next = shr_pkg::ST_TAKE_CHECK;
            end
            shr_pkg::ST_TAKE_CHECK: begin
                if (status.empty) begin
                    state_next = shr_pkg::ST_OUT;
                end else if (!status.newer) begin
                    cmd.drop_newest = 1'b1;
                    state_next      = shr_pkg::ST_READ_NEWEST;
                end else begin
                    cmd.pop_newest = 1'b1;
                    state_next     = shr_pkg::ST_OUT;
                end
            end
            shr_pkg::ST_TRIM_READ: begin
                cmd.rd_oldest = 1'b1;
                state_next    = shr_pkg::ST_TRIM;
            end
            shr_pkg::ST_TRIM: begin
                if (status.over_limit && !status.empty) begin
                    cmd.drop_oldest = 1'b1;
                    state_next      = shr_pkg::ST_TRIM_READ;
                end else begin
                    state_next = shr_pkg::ST_OUT;
                end
            end
            shr_pkg::ST_OUT: begin
                if (!ovalid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = shr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = shr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/shr_dp.sv */
module shr_dp #(
    parameter int DEPTH      = shr_pkg::DEPTH_DEF,
    parameter int FRAME_BITS = shr_pkg::FRAME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  shr_pkg::cmd_t                      cmd,
    output shr_pkg::status_t                   status,
    input  logic [1:0]                         in_op,
    input  logic [FRAME_BITS-1:0]              in_frame,
    input  logic [shr_pkg::SIZE_BITS-1:0]      in_size,
    input  logic                               cfg_we,
    input  logic [shr_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
    input  logic [shr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                               o_ok,
    output logic [FRAME_BITS-1:0]              o_frame,
    output logic [shr_pkg::SIZE_BITS-1:0]      o_size,
    output logic [$clog2(DEPTH)-1:0]           o_slot,
    output logic                               o_due,
    output logic                               o_rewind,
    output logic [$clog2(DEPTH+1)-1:0]         o_count,
    output logic [shr_pkg::LIMIT_BITS-1:0]     o_total,
    output logic [shr_pkg::DISC_BITS-1:0]      o_discards
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int SW = shr_pkg::SIZE_BITS;
    localparam int LW = shr_pkg::LIMIT_BITS;
    localparam int IW = shr_pkg::INTV_BITS;
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic                  enabled_reg;
    logic [LW-1:0]         limit_reg;
    logic [IW-1:0]         intv_reg;
    logic [1:0]            op_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [SW-1:0]         size_reg;
    logic [AW-1:0]         oldest_reg, oldest_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [LW-1:0]         total_reg, total_next;
    logic [shr_pkg::DISC_BITS-1:0] disc_reg, disc_next;
    logic                  due_reg, rewind_reg, ok_reg;
    logic [AW-1:0]         slot_reg;
    logic [FRAME_BITS-1:0] ffound_reg;
    logic [SW-1:0]         sfound_reg;
    // restoring remainder, one bit per cycle
    logic [FRAME_BITS-1:0] mq_reg;
    logic [IW:0]           mr_reg;
    logic [$clog2(FRAME_BITS+1)-1:0] mcnt_reg;
    logic [IW:0]           mr_shift;

    logic [AW-1:0]         raddr, waddr;
    logic [FRAME_BITS-1:0] rframe;
    logic [SW-1:0]         rsize;
    logic                  cfg_change;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] r;
        r = (v >= DEPTH_W) ? v - DEPTH_W : v;
        return r[AW-1:0];
    endfunction

    always_comb begin
        raddr = wrap({1'b0, oldest_reg} + (AW+1)'(count_reg) - (AW+1)'(1));
        if (cmd.rd_oldest) begin
            raddr = oldest_reg;
        end
    end
    // on a full ring this is the oldest slot, freed by the drop in the same cycle
    assign waddr = wrap({1'b0, oldest_reg} + (AW+1)'(count_reg));

    shr_ram #(.WIDTH(FRAME_BITS), .DEPTH(DEPTH)) u_frames (
        .aclk(aclk), .we(cmd.write_new), .waddr(waddr), .wdata(frame_reg),
        .raddr(raddr), .rdata(rframe)
    );
    shr_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sizes (
        .aclk(aclk), .we(cmd.write_new), .waddr(waddr), .wdata(size_reg),
        .raddr(raddr), .rdata(rsize)
    );

    always_comb begin
        cfg_change = 1'b0;
        if (cfg_we) begin
            unique case (cfg_idx)
                shr_pkg::CFG_ENABLED:
                    cfg_change = cfg_data[0] != enabled_reg;
                shr_pkg::CFG_LIMIT:
                    cfg_change = cfg_data != '0 && cfg_data != limit_reg;
                shr_pkg::CFG_INTERVAL:
                    cfg_change = cfg_data[IW-1:0] != '0 && cfg_data[IW-1:0] != intv_reg;
                default: cfg_change = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            limit_reg   <= shr_pkg::LIMIT_RESET;
            intv_reg    <= shr_pkg::INTV_RESET;
        end else if (cfg_change) begin
            unique case (cfg_idx)
                shr_pkg::CFG_ENABLED:  enabled_reg <= cfg_data[0];
                shr_pkg::CFG_LIMIT:    limit_reg   <= cfg_data;
                shr_pkg::CFG_INTERVAL: intv_reg    <= cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    // ring bookkeeping; capture with full ring drops then writes in one step
    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        disc_next   = disc_reg;
        if (cmd.drop_oldest) begin
            oldest_next = wrap({1'b0, oldest_reg} + (AW+1)'(1));
            count_next  = count_next - CW'(1);
            total_next  = total_next - LW'(rsize);
            disc_next   = disc_next + 1'b1;
        end
        if (cmd.drop_newest) begin
            count_next = count_reg - CW'(1);
            total_next = total_reg - LW'(rsize);
            disc_next  = disc_reg + 1'b1;
        end
        if (cmd.pop_newest) begin
            count_next = count_reg - CW'(1);
            total_next = total_reg - LW'(rsize);
        end
        if (cmd.write_new) begin
            count_next = count_next + CW'(1);
            total_next = total_next + LW'(size_reg);
        end
        if (cmd.clear || cfg_change) begin
            count_next = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            disc_reg   <= '0;
        end else begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            disc_reg   <= disc_next;
        end
    end

    assign mr_shift = {mr_reg[IW-1:0], mq_reg[FRAME_BITS-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            frame_reg <= in_frame;
            size_reg  <= in_size;
            ok_reg    <= 1'b0;
            due_reg   <= 1'b0;
            rewind_reg<= 1'b0;
            slot_reg  <= '0;
            ffound_reg<= '0;
            sfound_reg<= '0;
        end
        if (cmd.write_new) begin
            ok_reg   <= 1'b1;
            slot_reg <= waddr;
        end
        if (cmd.pop_newest) begin
            ok_reg     <= 1'b1;
            slot_reg   <= raddr;
            ffound_reg <= rframe;
            sfound_reg <= rsize;
        end
        if (cmd.set_due) begin
            due_reg <= 1'b1;
        end
        if (cmd.mod_start) begin
            mq_reg   <= frame_reg;
            mr_reg   <= '0;
            mcnt_reg <= '0;
        end
        if (cmd.mod_step) begin
            mq_reg   <= {mq_reg[FRAME_BITS-2:0], 1'b0};
            mcnt_reg <= mcnt_reg + 1'b1;
            if (mr_shift >= {1'b0, intv_reg}) begin
                mr_reg <= mr_shift - {1'b0, intv_reg};
            end else begin
                mr_reg <= mr_shift;
            end
        end
        if (cmd.set_rewind) begin
            due_reg    <= due_reg && enabled_reg && status.mod_zero;
            rewind_reg <= status.rewind_ok;
        end
    end

    always_comb begin
        status.op         = shr_pkg::op_t'(op_reg);
        status.empty      = (count_reg == '0);
        status.full       = ({1'b0, count_reg} >= (CW+1)'(DEPTH));
        status.cap_ok     = enabled_reg && size_reg != '0 && LW'(size_reg) <= limit_reg;
        status.newer      = rframe < frame_reg;
        status.over_limit = total_reg > limit_reg;
        status.rewind_ok  = frame_reg >= FRAME_BITS'(2) && count_reg != '0 &&
                            rframe < frame_reg - FRAME_BITS'(1);
        status.mod_done   = (mcnt_reg == ($clog2(FRAME_BITS+1))'(FRAME_BITS));
        status.mod_zero   = (mr_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_ok       <= ok_reg;
            o_frame    <= ffound_reg;
            o_size     <= sfound_reg;
            o_slot     <= slot_reg;
            o_due      <= due_reg;
            o_rewind   <= rewind_reg;
            o_count    <= count_reg;
            o_total    <= total_reg;
            o_discards <= disc_reg;
        end
    end

endmodule

/* rtl/snapshot_history_ring.sv */
// snapshot_history_ring: one item at a time, next beat taken only after the result loads
// capture: refused at once, else drops the oldest on a full ring, writes, then evicts
// while over the limit; query runs the bit-serial remainder for the interval test
// take previous discards newest entries not below the frame, then pops; a held result stalls
// aresetn is synchronous, active low; ring empties, config registers go to defaults
module snapshot_history_ring #(
    parameter int DEPTH      = shr_pkg::DEPTH_DEF,
    parameter int FRAME_BITS = shr_pkg::FRAME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[1:0], frame_number, snapshot_size, zero fill
    input  logic [((2+FRAME_BITS+25+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok, found_frame, found_size, slot, capture_due, rewind_possible,
    // entry_count, total_bytes, discard_count, zero fill
    output logic [((1+FRAME_BITS+25+$clog2(DEPTH)+2+$clog2(DEPTH+1)+31+32+7)/8)*8-1:0]
                                              m_tdata,
    input  logic                              cfg_we,
    input  logic [shr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [shr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int SW = shr_pkg::SIZE_BITS;
    localparam int OW = 1+FRAME_BITS+SW+AW+2+CW+31+32;
    localparam int MW = ((OW+7)/8)*8;

    shr_pkg::cmd_t    cmd;
    shr_pkg::status_t status;

    logic                  o_ok, o_due, o_rewind;
    logic [FRAME_BITS-1:0] o_frame;
    logic [SW-1:0]         o_size;
    logic [AW-1:0]         o_slot;
    logic [CW-1:0]         o_count;
    logic [30:0]           o_total;
    logic [31:0]           o_discards;

    shr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .status(status), .cmd(cmd)
    );

    shr_dp #(.DEPTH(DEPTH), .FRAME_BITS(FRAME_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_op(s_tdata[1:0]),
        .in_frame(s_tdata[2 +: FRAME_BITS]),
        .in_size(s_tdata[2+FRAME_BITS +: SW]),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .o_ok(o_ok), .o_frame(o_frame), .o_size(o_size), .o_slot(o_slot),
        .o_due(o_due), .o_rewind(o_rewind), .o_count(o_count),
        .o_total(o_total), .o_discards(o_discards)
    );

    assign m_tdata = MW'({o_discards, o_total, o_count,
                          o_rewind, o_due, o_slot, o_size, o_frame, o_ok});

`ifndef ASSERT_OFF
    a_one_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.drop_oldest && !cmd.write_new)
        else $error("ring updated while idle");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, u_dp.count_reg} <= (CW+1)'(DEPTH)))
        else $error("entry count above depth");
    a_out_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");
`endif

endmodule

/* tb/snapshot_history_ring_test.sv */
`timescale 1ns / 100ps

module snapshot_history_ring_test;

    typedef struct packed {
        logic [24:0]     snap_size;
        logic [47:0]     frame;
        shr_pkg::op_t    op;
    } request_t;

    // packed from the top bit down, so the lowest field comes last
    typedef struct packed {
        logic [31:0] discards;
        logic [30:0] total;
        logic [6:0]  count;
        logic        rewind;
        logic        due;
        logic [5:0]  slot;
        logic [24:0] fsize;
        logic [47:0] fframe;
        logic        ok;
    } reply_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;

    snapshot_history_ring dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ring model
    logic [47:0] ring_frame [64];
    logic [24:0] ring_size  [64];
    logic [5:0]  ring_head;
    int          ring_count;
    longint      ring_bytes;
    logic [31:0] evictions;
    logic        en_reg;
    longint      budget;
    longint      interval;

    request_t pending[$];
    reply_t   awaited[$];
    request_t on_bus;
    int       tx_gap, rx_gap;
    int       mismatches;
    longint   cycles;
    bit       long_hold;

    function automatic void apply_register(logic [1:0] idx, logic [30:0] val);
        if (idx == shr_pkg::CFG_ENABLED) begin
            if (val[0] != en_reg) begin
                en_reg = val[0];
                ring_count = 0;
                ring_bytes = 0;
            end
        end else if (idx == shr_pkg::CFG_LIMIT) begin
            if (val != 0 && longint'(val) != budget) begin
                budget = longint'(val);
                ring_count = 0;
                ring_bytes = 0;
            end
        end else if (idx == shr_pkg::CFG_INTERVAL) begin
            if (val[15:0] != 0 && longint'(val[15:0]) != interval) begin
                interval = longint'(val[15:0]);
                ring_count = 0;
                ring_bytes = 0;
            end
        end
    endfunction

    function automatic void evict_oldest();
        ring_bytes -= ring_size[ring_head];
        ring_head++;
        ring_count--;
        evictions++;
    endfunction

    function automatic reply_t ring_step(request_t rq);
        reply_t r;
        logic [5:0] s;
        bit newer;
        r = '0;
        newer = ring_count == 0 || ring_frame[6'(ring_head + ring_count - 1)] < rq.frame;
        case (rq.op)
            shr_pkg::OP_CAPTURE: begin
                if (en_reg && rq.snap_size != 0 && longint'(rq.snap_size) <= budget
                        && newer) begin
                    if (ring_count >= 64) evict_oldest();
                    s = 6'(ring_head + ring_count);
                    ring_frame[s] = rq.frame;
                    ring_size[s] = rq.snap_size;
                    ring_count++;
                    ring_bytes += rq.snap_size;
                    while (ring_bytes > budget && ring_count > 0) evict_oldest();
                    r.ok = 1;
                    r.slot = s;
                end
            end
            shr_pkg::OP_TAKE: begin
                while (ring_count > 0 &&
                       ring_frame[6'(ring_head + ring_count - 1)] >= rq.frame) begin
                    ring_bytes -= ring_size[6'(ring_head + ring_count - 1)];
                    ring_count--;
                    evictions++;
                end
                if (ring_count > 0) begin
                    s = 6'(ring_head + ring_count - 1);
                    r.fframe = ring_frame[s];
                    r.fsize = ring_size[s];
                    ring_bytes -= ring_size[s];
                    ring_count--;
                    r.ok = 1;
                    r.slot = s;
                end
            end
            shr_pkg::OP_QUERY: begin
                r.due = en_reg && (longint'(rq.frame) % interval == 0) && newer;
                r.rewind = rq.frame >= 2 && ring_count > 0 &&
                           ring_frame[ring_head] < rq.frame - 48'd1;
            end
            default: begin
                ring_count = 0;
                ring_bytes = 0;
            end
        endcase
        r.count = 7'(ring_count);
        r.total = 31'(ring_bytes);
        r.discards = evictions;
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(posedge aclk)
        long_hold <= (cycles >= 4000 && cycles < 4600);

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited = {awaited, ring_step(on_bus)};
                tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if ((!s_tvalid || s_tready) && tx_gap == 0 && pending.size() > 0) begin
                on_bus = pending[0];
                pending.delete(0);
                s_tdata <= {5'b0, on_bus};
                s_tvalid <= 1;
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 0;
                if (tx_gap > 0) tx_gap--;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        reply_t got, want;
        if (!aresetn) begin
            m_tready <= 0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (awaited.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", got);
                end else begin
                    want = awaited[0];
                    awaited.delete(0);
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  exp %p\n  got %p", want, got);
                    end
                end
                rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_tready <= rx_gap == 0 && !long_hold;
        end
    end

    task automatic settle();
        while (pending.size() > 0 || s_tvalid || awaited.size() > 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        apply_register(idx, val);
    endtask

    function automatic void push_req(shr_pkg::op_t op, logic [47:0] fr, logic [24:0] sz);
        request_t rq;
        rq.op = op;
        rq.frame = fr;
        rq.snap_size = sz;
        pending = {pending, rq};
    endfunction

    task automatic random_phase(int n);
        logic [47:0] fr;
        longint cap;
        int pick;
        fr = $urandom_range(0, 1) ? 48'($urandom_range(0, 50))
                                  : {16'($urandom), 32'($urandom)};
        cap = budget < 16777216 ? budget : 16777216;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                fr = $urandom_range(0, 19) == 0 ? fr - 48'($urandom_range(0, 2))
                                                : fr + 48'($urandom_range(1, 3));
                if ($urandom_range(0, 24) == 0)
                    push_req(shr_pkg::OP_CAPTURE, fr, 25'($urandom));
                else
                    push_req(shr_pkg::OP_CAPTURE, fr,
                             25'($urandom_range(1, 32'(cap / $urandom_range(1, 40) + 1))));
            end else if (pick < 65) begin
                fr = fr - 48'($urandom_range(0, 8)) + 1;
                push_req(shr_pkg::OP_TAKE, fr, 25'($urandom));
            end else if (pick < 85) begin
                push_req(shr_pkg::OP_QUERY, fr + 48'($urandom_range(0, 4)) - 2,
                         25'($urandom));
            end else if (pick < 88) begin
                push_req(shr_pkg::OP_CLEAR, fr, 25'($urandom));
            end else begin
                push_req(shr_pkg::op_t'($urandom_range(0, 3)),
                         {16'($urandom), 32'($urandom)}, 25'($urandom));
            end
        end
        settle();
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = shr_pkg::CFG_ENABLED;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        long_hold = 0;
        ring_head = 0;
        ring_count = 0;
        ring_bytes = 0;
        evictions = 0;
        en_reg = 0;
        budget = shr_pkg::LIMIT_RESET;
        interval = shr_pkg::INTV_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // disabled after reset: captures refused, query never due
        push_req(shr_pkg::OP_CAPTURE, 48'd10, 25'd100);
        push_req(shr_pkg::OP_QUERY, 48'd10, 25'd0);
        settle();
        write_reg(shr_pkg::CFG_ENABLED, 31'd1);
        push_req(shr_pkg::OP_CAPTURE, 48'd0, 25'd1);
        push_req(shr_pkg::OP_CAPTURE, 48'd0, 25'd5);
        push_req(shr_pkg::OP_CAPTURE, 48'd3, 25'd0);
        push_req(shr_pkg::OP_CAPTURE, 48'd4, 25'd16777216);
        push_req(shr_pkg::OP_QUERY, 48'd0, 25'd0);
        push_req(shr_pkg::OP_QUERY, 48'd1, 25'd0);
        push_req(shr_pkg::OP_QUERY, 48'd2, 25'd0);
        push_req(shr_pkg::OP_QUERY, 48'd5, 25'd0);
        push_req(shr_pkg::OP_CAPTURE, 48'hFFFF_FFFF_FFFF, 25'h1FF_FFFF);
        push_req(shr_pkg::OP_TAKE, 48'hFFFF_FFFF_FFFF, 25'd0);
        push_req(shr_pkg::OP_TAKE, 48'd4, 25'd0);
        push_req(shr_pkg::OP_TAKE, 48'd0, 25'd0);
        push_req(shr_pkg::OP_TAKE, 48'd0, 25'd0);
        push_req(shr_pkg::OP_CAPTURE, 48'd7, 25'd9);
        push_req(shr_pkg::OP_CLEAR, 48'd0, 25'd0);
        push_req(shr_pkg::OP_QUERY, 48'hFFFF_FFFF_FFFF, 25'd0);
        settle();
        // zero writes are ignored
        write_reg(shr_pkg::CFG_LIMIT, 31'd0);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd0);
        random_phase(320);

        write_reg(shr_pkg::CFG_LIMIT, 31'd1);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd65535);
        push_req(shr_pkg::OP_CAPTURE, 48'd1, 25'd2);
        push_req(shr_pkg::OP_QUERY, 48'd65535, 25'd0);
        random_phase(200);

        write_reg(shr_pkg::CFG_LIMIT, 31'd1000);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd7);
        random_phase(300);

        write_reg(shr_pkg::CFG_ENABLED, 31'h7FFF_FFFE);
        write_reg(shr_pkg::CFG_LIMIT, 31'h7FFF_FFFF);
        write_reg(shr_pkg::CFG_INTERVAL, 31'h7FFF_0003);
        random_phase(150);

        write_reg(shr_pkg::CFG_ENABLED, 31'd1);
        write_reg(shr_pkg::CFG_LIMIT, 31'd16777216);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd1);
        random_phase(300);

        write_reg(shr_pkg::CFG_LIMIT, 31'd1073741824);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd2);
        random_phase(320);

        write_reg(shr_pkg::CFG_LIMIT, 31'd123457);
        write_reg(shr_pkg::CFG_INTERVAL, 31'd65535);
        random_phase(300);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/shr_pkg.sv
rtl/shr_ram.sv
rtl/shr_ctrl.sv
rtl/shr_dp.sv
rtl/snapshot_history_ring.sv
tb/snapshot_history_ring_test.sv
